// ===== design/imvq_pkg.sv =====
// Shared types and constants for the int8 matrix-vector core with activation quantization.
`default_nettype none
package imvq_pkg;

    localparam int unsigned MAX_LENGTH_DEF = 8192;
    localparam int unsigned VLEN_W         = 14;
    localparam int unsigned VLEN_RESET     = 896;
    localparam int unsigned ACT_W          = 32;
    localparam int unsigned WGT_W          = 8;
    localparam int unsigned ROW_W          = 16;
    localparam int unsigned DIV_W          = 72;
    localparam int unsigned DIV_CNT_W      = 7;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_WEIGHT = 1'b1;

    // Quantization range and output scaling constants
    localparam logic [7:0]  Q_MAX      = 8'd127;
    localparam logic [31:0] SCALE_DEN  = 32'd127;
    localparam logic [95:0] SCALE_HALF = 96'd127 << 23;

    // Divide by 127 in 16-bit digits: floor(x / 127) = (x * RECIP_127) >> RECIP_SHIFT
    // holds for every x below 127 * 2^16
    localparam logic [23:0] RECIP_127   = 24'd8454661;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam int unsigned SDIV_STEPS  = 3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_QREAD,
        ST_QSTART,
        ST_QDIV,
        ST_STREAM,
        ST_MAC,
        ST_SLO,
        ST_SHI,
        ST_SSUM,
        ST_SDIV,
        ST_SOUT
    } state_t;

endpackage
`default_nettype wire

// ===== design/imvq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module imvq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/int8_matvec_dynamic_act_quant_core.sv =====
// Top level: activation load, quantization pass, int8 row dot products and row scaling.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------------------
//  s_      | in        | s_valid / s_ready   | command, act_value, weight_value, row_scale,
//          |           |                     | end_of_row, end_of_matrix
//  m_      | out       | m_valid / m_ready   | y_value, row_index, last_row
//  cfg_    | in        | cfg_valid/cfg_ready | vector_length (14 bits)
//
// Loading accepts one activation element per cycle. The quantization pass runs once per
// vector, one element at a time through a 72-step restoring divider. A weight element
// goes through a memory read, then a multiply-accumulate, and no new item is taken until
// it is through. A row end adds the multiply and sum states (ST_SLO, ST_SHI, ST_SSUM),
// 3 divide-by-127 digit steps and an exit step before the result is issued in ST_SOUT.
// A waiting result stalls only the next row end. Reset is synchronous, active low; the
// stores need no clearing pass.
`default_nettype none
module int8_matvec_dynamic_act_quant_core #(
    parameter int unsigned MAX_LENGTH = imvq_pkg::MAX_LENGTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [imvq_pkg::VLEN_W-1:0]   cfg_data,
    // input items
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_command,
    input  wire logic signed [imvq_pkg::ACT_W-1:0] s_act_value,
    input  wire logic signed [imvq_pkg::WGT_W-1:0] s_weight_value,
    input  wire logic [31:0]                   s_row_scale,
    input  wire logic                          s_end_of_row,
    input  wire logic                          s_end_of_matrix,
    // results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [imvq_pkg::ACT_W-1:0]  m_y_value,
    output logic [imvq_pkg::ROW_W-1:0]         m_row_index,
    output logic                               m_last_row
);

    import imvq_pkg::*;

    localparam int unsigned AW = $clog2(MAX_LENGTH);
    localparam int unsigned CW = $clog2(MAX_LENGTH + 1);

    // Control state
    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        qlen_reg, qlen_next;
    logic [31:0]          maxabs_reg, maxabs_next;
    logic [31:0]          acc_reg, acc_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [VLEN_W-1:0]    vlen_reg, vlen_next;
    logic                 mvalid_reg, mvalid_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;

    // Datapath registers
    logic signed [WGT_W-1:0] w_reg, w_next;
    logic                 eor_reg, eor_next;
    logic                 eom_reg, eom_next;
    logic [31:0]          scale_reg, scale_next;
    logic                 inrange_reg, inrange_next;
    logic                 xneg_reg, xneg_next;
    logic [31:0]          drem_reg, drem_next;
    logic [DIV_W-1:0]     dquo_reg, dquo_next;
    logic [31:0]          dden_reg, dden_next;
    logic [63:0]          p_reg, p_next;
    logic [31:0]          s_reg, s_next;
    logic                 sneg_reg, sneg_next;
    logic [63:0]          pl_reg, pl_next;
    logic [63:0]          ph_reg, ph_next;
    logic [ACT_W-1:0]     y_reg, y_next;
    logic [ROW_W-1:0]     ridx_reg, ridx_next;
    logic                 last_reg, last_next;

    // Memory ports
    logic                 act_we;
    logic [ACT_W-1:0]     act_rdata;
    logic                 q_we;
    logic [WGT_W-1:0]     q_wdata;
    logic [WGT_W-1:0]     q_rdata;

    // Helpers
    logic                 s_hs;
    logic [CW-1:0]        eff_len;
    logic [CW-1:0]        cnt_inc;
    logic [31:0]          in_mag;
    logic [31:0]          x_mag;
    logic [32:0]          div_t;
    logic                 div_ge;
    logic [32:0]          rr2;
    logic                 q_up;
    logic [8:0]           q_round;
    logic [WGT_W-1:0]     q_mag;
    logic signed [15:0]   prod;
    logic [31:0]          acc_sum;
    logic [95:0]          scaled_sum;
    logic [ACT_W-1:0]     y_sat;
    logic [22:0]          sd_x;
    logic [45:0]          sd_prod;
    logic [15:0]          sd_q;
    logic [22:0]          sd_r;

    imvq_ram #(.WIDTH(ACT_W), .DEPTH(MAX_LENGTH)) u_act_ram (
        .aclk  (aclk),
        .we    (act_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_act_value),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (act_rdata)
    );

    imvq_ram #(.WIDTH(WGT_W), .DEPTH(MAX_LENGTH)) u_q_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (q_wdata),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (q_rdata)
    );

    // Clamp the configured length to the store depth; a length of zero counts as one
    always_comb begin
        if (vlen_reg == '0) begin
            eff_len = CW'(1);
        end else if (32'(vlen_reg) > MAX_LENGTH) begin
            eff_len = CW'(MAX_LENGTH);
        end else begin
            eff_len = CW'(vlen_reg);
        end
    end

    assign s_hs    = s_valid && s_ready;
    assign cnt_inc = cnt_reg + CW'(1);
    assign in_mag  = s_act_value[31] ? (~s_act_value + 32'd1) : s_act_value;
    assign x_mag   = act_rdata[31] ? (~act_rdata + 32'd1) : act_rdata;

    // One restoring divide step
    assign div_t  = {drem_reg, dquo_reg[DIV_W-1]};
    assign div_ge = div_t >= {1'b0, dden_reg};

    // Round half to even on the quantizer quotient, then clamp
    assign rr2     = {drem_reg, 1'b0};
    assign q_up    = (rr2 > {1'b0, dden_reg}) || ((rr2 == {1'b0, dden_reg}) && dquo_reg[0]);
    assign q_round = {1'b0, dquo_reg[7:0]} + {8'd0, q_up};
    always_comb begin
        if ((|dquo_reg[DIV_W-1:8]) || (q_round > {1'b0, Q_MAX})) begin
            q_mag = Q_MAX;
        end else begin
            q_mag = q_round[7:0];
        end
    end

    // Multiply-accumulate of one weight element
    assign prod    = 16'($signed(q_rdata)) * 16'(w_reg);
    assign acc_sum = inrange_reg ? (acc_reg + {{16{prod[15]}}, prod}) : acc_reg;

    // Full product plus half the divisor ahead of the divide by 127 * 2^24
    assign scaled_sum = {32'd0, pl_reg} + {ph_reg[63:0], 32'd0} + SCALE_HALF;

    // One 16-bit digit of the divide by 127: reciprocal multiply, then remainder
    assign sd_x    = {drem_reg[6:0], dquo_reg[47:32]};
    assign sd_prod = 46'(sd_x) * 46'(RECIP_127);
    assign sd_q    = sd_prod[RECIP_SHIFT+15:RECIP_SHIFT];
    assign sd_r    = sd_x - 23'(sd_q) * 23'(SCALE_DEN);

    // Saturate the signed row result
    always_comb begin
        if (sneg_reg) begin
            if (dquo_reg > DIV_W'(33'h0_8000_0000)) begin
                y_sat = 32'h8000_0000;
            end else begin
                y_sat = ~dquo_reg[31:0] + 32'd1;
            end
        end else begin
            if (dquo_reg > DIV_W'(32'h7FFF_FFFF)) begin
                y_sat = 32'h7FFF_FFFF;
            end else begin
                y_sat = dquo_reg[31:0];
            end
        end
    end

    // Next state and datapath
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        qlen_next    = qlen_reg;
        maxabs_next  = maxabs_reg;
        acc_next     = acc_reg;
        row_next     = row_reg;
        vlen_next    = vlen_reg;
        mvalid_next  = mvalid_reg && !m_ready;
        dcnt_next    = dcnt_reg;
        w_next       = w_reg;
        eor_next     = eor_reg;
        eom_next     = eom_reg;
        scale_next   = scale_reg;
        inrange_next = inrange_reg;
        xneg_next    = xneg_reg;
        drem_next    = drem_reg;
        dquo_next    = dquo_reg;
        dden_next    = dden_reg;
        p_next       = p_reg;
        s_next       = s_reg;
        sneg_next    = sneg_reg;
        pl_next      = pl_reg;
        ph_next      = ph_reg;
        y_next       = y_reg;
        ridx_next    = ridx_reg;
        last_next    = last_reg;
        act_we       = 1'b0;
        q_we         = 1'b0;
        q_wdata      = '0;
        s_ready      = (state_reg == ST_LOAD) || (state_reg == ST_STREAM);

        if (cfg_valid) begin
            vlen_next = cfg_data;
        end

        unique case (state_reg)
            ST_LOAD: begin
                // Store the element and track the largest magnitude
                if (s_hs && (s_command == CMD_LOAD)) begin
                    act_we = 1'b1;
                    if (in_mag > maxabs_reg) begin
                        maxabs_next = in_mag;
                    end
                    if (cnt_inc >= eff_len) begin
                        state_next = ST_QREAD;
                        qlen_next  = eff_len;
                        cnt_next   = '0;
                        acc_next   = '0;
                        row_next   = '0;
                    end else begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_QREAD: begin
                state_next = ST_QSTART;
            end
            ST_QSTART: begin
                xneg_next = act_rdata[31];
                if (maxabs_reg == '0) begin
                    q_we     = 1'b1;
                    q_wdata  = '0;
                    cnt_next = cnt_inc;
                    state_next = (cnt_inc == qlen_reg) ? ST_STREAM : ST_QREAD;
                    if (cnt_inc == qlen_reg) begin
                        cnt_next = '0;
                    end
                end else begin
                    drem_next  = '0;
                    dquo_next  = DIV_W'({x_mag, 7'd0} - {7'd0, x_mag});
                    dden_next  = maxabs_reg;
                    dcnt_next  = '0;
                    state_next = ST_QDIV;
                end
            end
            ST_QDIV: begin
                if (dcnt_reg == DIV_CNT_W'(DIV_W)) begin
                    // Write the signed quantized element and advance
                    q_we    = 1'b1;
                    q_wdata = xneg_reg ? (~q_mag + 8'd1) : q_mag;
                    if (cnt_inc == qlen_reg) begin
                        cnt_next   = '0;
                        state_next = ST_STREAM;
                    end else begin
                        cnt_next   = cnt_inc;
                        state_next = ST_QREAD;
                    end
                end else begin
                    drem_next = div_ge ? 32'(div_t - {1'b0, dden_reg}) : div_t[31:0];
                    dquo_next = {dquo_reg[DIV_W-2:0], div_ge};
                    dcnt_next = dcnt_reg + DIV_CNT_W'(1);
                end
            end
            ST_STREAM: begin
                // Take a weight element and fetch its quantized activation
                if (s_hs && (s_command == CMD_WEIGHT)) begin
                    w_next       = s_weight_value;
                    eor_next     = s_end_of_row;
                    eom_next     = s_end_of_matrix;
                    scale_next   = s_row_scale;
                    inrange_next = cnt_reg < eff_len;
                    if (32'(cnt_reg) < MAX_LENGTH) begin
                        cnt_next = cnt_inc;
                    end
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (eor_reg) begin
                    s_next     = acc_sum[31] ? (~acc_sum + 32'd1) : acc_sum;
                    sneg_next  = acc_sum[31];
                    p_next     = 64'(maxabs_reg) * 64'(scale_reg);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SLO;
                end else begin
                    acc_next   = acc_sum;
                    state_next = ST_STREAM;
                end
            end
            ST_SLO: begin
                pl_next    = 64'(p_reg[31:0]) * 64'(s_reg);
                state_next = ST_SHI;
            end
            ST_SHI: begin
                ph_next    = 64'(p_reg[63:32]) * 64'(s_reg);
                state_next = ST_SSUM;
            end
            ST_SSUM: begin
                drem_next  = '0;
                dquo_next  = scaled_sum[95:24];
                dcnt_next  = '0;
                state_next = ST_SDIV;
            end
            ST_SDIV: begin
                // Shift in one quotient digit per cycle, keep the top bits for saturation
                if (dcnt_reg == DIV_CNT_W'(SDIV_STEPS)) begin
                    state_next = ST_SOUT;
                end else begin
                    drem_next = {9'd0, sd_r};
                    dquo_next = {dquo_reg[DIV_W-1:48], dquo_reg[31:0], sd_q};
                    dcnt_next = dcnt_reg + DIV_CNT_W'(1);
                end
            end
            ST_SOUT: begin
                // Hold until the output register is free, then issue the row result
                if (!mvalid_reg || m_ready) begin
                    mvalid_next = 1'b1;
                    y_next      = y_sat;
                    ridx_next   = row_reg;
                    last_next   = eom_reg;
                    if (eom_reg) begin
                        maxabs_next = '0;
                        row_next    = '0;
                        state_next  = ST_LOAD;
                    end else begin
                        row_next    = row_reg + ROW_W'(1);
                        state_next  = ST_STREAM;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            qlen_reg   <= '0;
            maxabs_reg <= '0;
            acc_reg    <= '0;
            row_reg    <= '0;
            vlen_reg   <= VLEN_W'(VLEN_RESET);
            mvalid_reg <= 1'b0;
            dcnt_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            qlen_reg   <= qlen_next;
            maxabs_reg <= maxabs_next;
            acc_reg    <= acc_next;
            row_reg    <= row_next;
            vlen_reg   <= vlen_next;
            mvalid_reg <= mvalid_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        w_reg       <= w_next;
        eor_reg     <= eor_next;
        eom_reg     <= eom_next;
        scale_reg   <= scale_next;
        inrange_reg <= inrange_next;
        xneg_reg    <= xneg_next;
        drem_reg    <= drem_next;
        dquo_reg    <= dquo_next;
        dden_reg    <= dden_next;
        p_reg       <= p_next;
        s_reg       <= s_next;
        sneg_reg    <= sneg_next;
        pl_reg      <= pl_next;
        ph_reg      <= ph_next;
        y_reg       <= y_next;
        ridx_reg    <= ridx_next;
        last_reg    <= last_next;
    end

    assign cfg_ready   = 1'b1;
    assign m_valid     = mvalid_reg;
    assign m_y_value   = y_reg;
    assign m_row_index = ridx_reg;
    assign m_last_row  = last_reg;

    // Load and element counters never run past the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= MAX_LENGTH)
        else $error("element counter beyond store depth");

    // A fresh vector starts with a cleared maximum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && cnt_reg == '0) |-> (maxabs_reg == '0))
        else $error("maximum not cleared at vector start");

    // Divider step count stays within its range
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(dcnt_reg) <= DIV_W)
        else $error("divider step count out of range");

    // A result only appears from the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mvalid_reg) |-> ($past(state_reg) == ST_SOUT))
        else $error("result issued outside the output state");

endmodule
`default_nettype wire

// ===== verif/imvq_checker.sv =====
`timescale 1ns / 1ps
// Checker for the int8 matvec core: predicts row results from observed transactions and compares.
module imvq_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [13:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_command,
    input  wire logic [31:0] s_act_value,
    input  wire logic [7:0]  s_weight_value,
    input  wire logic [31:0] s_row_scale,
    input  wire logic        s_end_of_row,
    input  wire logic        s_end_of_matrix,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_y_value,
    input  wire logic [15:0] m_row_index,
    input  wire logic        m_last_row,
    output int               fail_count,
    output int               rows_pending
);
    import imvq_pkg::*;

    localparam int unsigned MAXLEN = MAX_LENGTH_DEF;

    typedef struct packed {
        logic [31:0] y_value;
        logic [15:0] row_index;
        logic        last_row;
    } row_result_t;

    row_result_t expected_rows[$];

    logic [31:0]       act_mem [MAXLEN];
    logic signed [7:0] qnt_mem [MAXLEN];
    logic [31:0]       max_mag;
    int unsigned       position;
    logic [31:0]       dot_acc;
    logic [15:0]       row_count;
    logic              streaming;
    logic [13:0]       vec_len;

    function automatic int unsigned eff_len(logic [13:0] n);
        if (n == 0) return 1;
        if (n > MAXLEN) return MAXLEN;
        return n;
    endfunction

    function automatic logic [31:0] abs32(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // Quantize one stored activation against the vector's largest magnitude
    function automatic logic signed [7:0] quantize_elem(logic [31:0] x, logic [31:0] mx);
        logic [63:0] num, qq, r;
        if (mx == 0) return 8'sd0;
        num = 64'(abs32(x)) * 64'd127;
        qq  = num / mx;
        r   = num % mx;
        if (2 * r > mx || (2 * r == mx && qq[0])) qq++;
        if (qq > 127) qq = 127;
        return x[31] ? -8'(qq) : 8'(qq);
    endfunction

    // Scale the dot product by maxabs*row_scale/(127*2^24), round, saturate
    function automatic logic [31:0] scale_row(logic [31:0] acc, logic [31:0] mx,
                                              logic [31:0] scale);
        logic [63:0] den, s, p, a, b, bs, mag, rr;
        den = 64'd127 << 24;
        s   = 64'(abs32(acc));
        p   = 64'(mx) * 64'(scale);
        a   = p / den;
        b   = p % den;
        bs  = b * s;
        mag = a * s + bs / den;
        rr  = bs % den;
        if (2 * rr >= den) mag++;
        if (acc[31]) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return ~mag[31:0] + 32'd1;
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    always @(posedge aclk) begin
        int unsigned len;
        row_result_t got, want, pred;
        if (!aresetn) begin
            position  = 0;
            dot_acc   = '0;
            row_count = '0;
            streaming = 1'b0;
            vec_len   = 14'(VLEN_RESET);
            max_mag   = '0;
            fail_count = 0;
            expected_rows.delete();
            rows_pending = 0;
        end else begin
            // compare accepted result against the oldest expectation
            if (m_valid && m_ready) begin
                got = '{m_y_value, m_row_index, m_last_row};
                if (expected_rows.size() == 0) begin
                    $error("unexpected row result y_value=%0d row_index=%0d",
                           $signed(m_y_value), m_row_index);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_rows.pop_front();
                    if (got.y_value !== want.y_value) begin
                        $error("y_value expected %0d actual %0d",
                               $signed(want.y_value), $signed(got.y_value));
                        fail_count = fail_count + 1;
                    end
                    if (got.row_index !== want.row_index) begin
                        $error("row_index expected %0d actual %0d",
                               want.row_index, got.row_index);
                        fail_count = fail_count + 1;
                    end
                    if (got.last_row !== want.last_row) begin
                        $error("last_row expected %0d actual %0d",
                               want.last_row, got.last_row);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) vec_len = cfg_data;
            // advance the prediction on each accepted input transaction
            if (s_valid && s_ready) begin
                len = eff_len(vec_len);
                if (s_command == CMD_LOAD) begin
                    if (!streaming) begin
                        if (position < MAXLEN) act_mem[position] = s_act_value;
                        if (abs32(s_act_value) > max_mag) max_mag = abs32(s_act_value);
                        position++;
                        if (position >= len) begin
                            for (int k = 0; k < len; k++)
                                qnt_mem[k] = quantize_elem(act_mem[k], max_mag);
                            streaming = 1'b1;
                            position  = 0;
                            dot_acc   = '0;
                            row_count = '0;
                        end
                    end
                end else if (streaming) begin
                    if (position < len)
                        dot_acc += 32'(32'(qnt_mem[position]) * 32'($signed(s_weight_value)));
                    if (position < MAXLEN) position++;
                    if (s_end_of_row) begin
                        pred = '{scale_row(dot_acc, max_mag, s_row_scale),
                                 row_count, s_end_of_matrix};
                        expected_rows.insert(expected_rows.size(), pred);
                        row_count++;
                        dot_acc  = '0;
                        position = 0;
                        if (s_end_of_matrix) begin
                            streaming = 1'b0;
                            max_mag   = '0;
                            row_count = '0;
                        end
                    end
                end
            end
            rows_pending = expected_rows.size();
        end
    end
endmodule

// ===== verif/tb_int8_matvec_dynamic_act_quant_core.sv =====
`timescale 1ns / 1ps
// Testbench top: stimulus, flow control and verdict for the int8 matvec core.
module tb_int8_matvec_dynamic_act_quant_core;
    import imvq_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int SETTLE      = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [13:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = CMD_LOAD;
    logic [31:0] s_act_value = '0;
    logic [7:0]  s_weight_value = '0;
    logic [31:0] s_row_scale = '0;
    logic        s_end_of_row = 1'b0;
    logic        s_end_of_matrix = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_y_value;
    logic [15:0] m_row_index;
    logic        m_last_row;
    int          fail_count;
    int          rows_pending;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int items_sent = 0;
    int stall_count = 0;
    int cur_len = 4;

    always #1 aclk = ~aclk;

    int8_matvec_dynamic_act_quant_core u_dut (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_command, .s_act_value, .s_weight_value, .s_row_scale,
        .s_end_of_row, .s_end_of_matrix,
        .m_valid, .m_ready, .m_y_value, .m_row_index, .m_last_row
    );

    imvq_checker u_checker (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_command, .s_act_value, .s_weight_value, .s_row_scale,
        .s_end_of_row, .s_end_of_matrix,
        .m_valid, .m_ready, .m_y_value, .m_row_index, .m_last_row,
        .fail_count, .rows_pending
    );

    // Watchdog: end the run after too many cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) || !aresetn)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random backpressure plus one long hold-off in the last random phase
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(logic cmd, logic [31:0] act, logic [7:0] w, logic [31:0] scale,
                             logic eor, logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid         = 1'b1;
        s_command       = cmd;
        s_act_value     = act;
        s_weight_value  = w;
        s_row_scale     = scale;
        s_end_of_row    = eor;
        s_end_of_matrix = eom;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic write_length(logic [13:0] value);
        @(negedge aclk);
        s_valid   = 1'b0;
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        cur_len = (value == 0) ? 1 : ((value > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : value);
    endtask

    // Wait until every predicted row has arrived, then let the core settle
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (rows_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_act(bit zero_vec);
        if (zero_vec) return '0;
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000);
            2: return {{12{$urandom_range(1) == 1}}, 20'($urandom())};
            default: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(32'h0100_0000);
            default: return $urandom_range(32'h0002_0000);
        endcase
    endfunction

    // One well-formed vector load and matrix with some noise mixed in
    task automatic run_matrix();
        bit zero_vec;
        int nrows, rlen;
        zero_vec = ($urandom_range(9) == 0);
        for (int i = 0; i < cur_len; i++) begin
            if ($urandom_range(19) == 0)
                send_item(CMD_WEIGHT, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            send_item(CMD_LOAD, rand_act(zero_vec), $urandom(), $urandom(), $urandom(),
                      $urandom());
        end
        nrows = $urandom_range(1, 4);
        for (int r = 0; r < nrows; r++) begin
            case ($urandom_range(9))
                0: rlen = $urandom_range(1, cur_len);
                1: rlen = cur_len + $urandom_range(1, 3);
                default: rlen = cur_len;
            endcase
            for (int j = 0; j < rlen; j++) begin
                if ($urandom_range(19) == 0)
                    send_item(CMD_LOAD, $urandom(), $urandom(), $urandom(), 1'b1, 1'b1);
                if (j == rlen - 1)
                    send_item(CMD_WEIGHT, $urandom(), $urandom(), rand_scale(), 1'b1,
                              r == nrows - 1);
                else
                    send_item(CMD_WEIGHT, $urandom(), $urandom(), $urandom(), 1'b0,
                              $urandom_range(19) == 0);
            end
        end
    endtask

    task automatic random_phase(int count, int s_pct, int r_pct, bit with_hold);
        int stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = items_sent + count;
        if (with_hold) hold_cycles = 4000;
        while (items_sent < stop_at) begin
            if ($urandom_range(4) == 0) begin
                drain();
                if ($urandom_range(7) == 0) write_length($urandom_range(33, 64));
                else write_length($urandom_range(0, 12));
            end
            run_matrix();
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        recv_idle_pct = 30;

        // Directed: extremes, wrong phase, short and long rows, stray matrix end
        write_length(14'd4);
        send_item(CMD_WEIGHT, '0, 8'h7F, '1, 1'b1, 1'b1);
        send_item(CMD_LOAD, 32'h8000_0000, '0, '0, 1'b0, 1'b0);
        send_item(CMD_LOAD, 32'h7FFF_FFFF, '0, '0, 1'b1, 1'b1);
        send_item(CMD_LOAD, 32'h0000_0000, '0, '0, 1'b0, 1'b0);
        send_item(CMD_LOAD, 32'h0000_0001, '0, '0, 1'b0, 1'b0);
        send_item(CMD_WEIGHT, '0, 8'h7F, '0, 1'b0, 1'b1);
        send_item(CMD_WEIGHT, '0, 8'h80, '0, 1'b0, 1'b0);
        send_item(CMD_WEIGHT, '0, 8'h7F, '0, 1'b0, 1'b0);
        send_item(CMD_WEIGHT, '0, 8'h80, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_item(CMD_LOAD, 32'h1234_5678, '0, '0, 1'b0, 1'b0);
        send_item(CMD_WEIGHT, '0, 8'h80, '0, 1'b1, 1'b0);
        for (int i = 0; i < 5; i++)
            send_item(CMD_WEIGHT, '0, 8'h81, 32'h0100_0000, i == 4, i == 4);
        drain();
        // Minimum length with an all-zero vector
        write_length(14'd0);
        send_item(CMD_LOAD, '0, '0, '0, 1'b0, 1'b0);
        send_item(CMD_WEIGHT, '0, 8'h05, 32'hFFFF_FFFF, 1'b1, 1'b1);
        drain();
        // Length lowered mid-load: quantization starts on the next element
        write_length(14'h3FFF);
        send_item(CMD_LOAD, 32'hFFFF_0000, '0, '0, 1'b0, 1'b0);
        send_item(CMD_LOAD, 32'h0003_0000, '0, '0, 1'b0, 1'b0);
        send_item(CMD_LOAD, 32'h0000_8000, '0, '0, 1'b0, 1'b0);
        drain();
        write_length(14'd2);
        send_item(CMD_LOAD, 32'h0001_8000, '0, '0, 1'b0, 1'b0);
        send_item(CMD_WEIGHT, '0, 8'h40, '0, 1'b0, 1'b0);
        send_item(CMD_WEIGHT, '0, 8'hC0, 32'h0200_0000, 1'b1, 1'b1);
        drain();

        // Random: three flow-control regimes, with one long result hold-off
        random_phase(530, 18, 77, 1'b0);
        random_phase(530, 77, 18, 1'b0);
        random_phase(540, 0, 0, 1'b1);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/imvq_pkg.sv
design/imvq_ram.sv
design/int8_matvec_dynamic_act_quant_core.sv
verif/imvq_checker.sv
verif/tb_int8_matvec_dynamic_act_quant_core.sv
